@@ rtl/tsm_pkg.sv @@
// shared types and constants for the per-core time share monitor
// no dependencies

package tsm_pkg;

   localparam int CORE_COUNT = 128;
   localparam int CORE_AW    = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
   localparam int CORE_W     = 7;
   localparam int CNT_W      = 64;
   localparam int SHARE_W    = 15;
   localparam int M_W        = 69;
   localparam int SERIAL_LEN = 69;
   localparam int DIV_STEPS  = 15;
   localparam int REQ_W      = 520;
   localparam int RSP_W      = 72;

   localparam logic [SHARE_W-1:0] SHARE_FULL = 15'd25600;

   localparam logic [1:0] MODE_FOUR  = 2'd0;
   localparam logic [1:0] MODE_SEVEN = 2'd1;
   localparam logic [1:0] MODE_EIGHT = 2'd2;

   // counter order in the request
   localparam int IX_USER  = 0;
   localparam int IX_NICE  = 1;
   localparam int IX_SYS   = 2;
   localparam int IX_IDLE  = 3;
   localparam int IX_IOW   = 4;
   localparam int IX_IRQ   = 5;
   localparam int IX_SIRQ  = 6;
   localparam int IX_STEAL = 7;

   // category order, total last
   localparam int CAT_IDLE  = 0;
   localparam int CAT_USER  = 1;
   localparam int CAT_SYS   = 2;
   localparam int CAT_IOW   = 3;
   localparam int CAT_TOTAL = 4;

   typedef logic [7:0][CNT_W-1:0] tsm_counts_type;
   typedef logic [4:0][CNT_W-1:0] tsm_prev_type;
   typedef logic [3:0][M_W-1:0]   tsm_prod_type;

   typedef struct packed {
      logic [3:0] num_zero;
      logic [3:0] cat_ge;
      logic       den_zero;
   } tsm_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SERIAL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_WRITE
   } tsm_state_type;

endpackage

@@ rtl/per_core_time_share_monitor_core.sv @@
// top level of the per-core time share monitor: control, per-core store, output register
// depends on tsm_pkg, tsm_front and tsm_div

// One counter sample is taken at a time. A sample for a core inside the store passes
// through the store read and load, then the bit-serial pass that forms sums, deltas
// and the times-25 products, then four shares, one after another, on the one shared
// bit-per-cycle divider. A core index beyond the store gives a result with all shares
// zero. The next sample is taken while a result still waits in the output register.
// The per-core store starts out all zero after reset through valid bits, with no
// clearing pass.

module per_core_time_share_monitor_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // core_index, user, nice, system, idle, iowait, irq, softirq, steal, zero pad
   input  logic [tsm_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // core_echo, idle_share, user_share, system_share, iowait_share, zero pad
   output logic [tsm_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_wen,
   input  logic [1:0]                 csr_wdata
);
   import tsm_pkg::*;

   tsm_state_type state_ff, state_in;
   logic [6:0]         cnt_ff;
   logic [1:0]         cat_ff;
   logic [CORE_W-1:0]  core_ff;
   logic               in_range_ff;
   logic [1:0]         mode_ff;
   logic [3:0][SHARE_W-1:0] share_ff;
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   logic [CNT_W-1:0] mem_idle [CORE_COUNT];
   logic [CNT_W-1:0] mem_user [CORE_COUNT];
   logic [CNT_W-1:0] mem_sys  [CORE_COUNT];
   logic [CNT_W-1:0] mem_iow  [CORE_COUNT];
   logic [CNT_W-1:0] mem_tot  [CORE_COUNT];
   logic [CORE_COUNT-1:0] row_valid_ff, iow_valid_ff;
   logic [CNT_W-1:0] rd_idle_ff, rd_user_ff, rd_sys_ff, rd_iow_ff, rd_tot_ff;
   logic             rd_row_ff, rd_iow_v_ff;

   logic               accept, out_free, req_in_range, load_prev, step, div_start, mem_we;
   logic [CORE_AW-1:0] addr;
   tsm_counts_type     counts;
   tsm_prev_type       prev;
   tsm_prod_type       prod;
   logic [63:0]        den, new_total, new_sys, cur_idle, cur_user, cur_iow;
   tsm_flags_type      flags;
   logic               div_done;
   logic [SHARE_W-1:0] quot, share_sel;

   assign accept       = req_tvalid & req_tready;
   assign out_free     = ~rsp_valid_ff | rsp_tready;
   assign req_in_range = 32'(req_tdata[CORE_W-1:0]) < CORE_COUNT;
   assign addr         = CORE_AW'(core_ff);

   always_comb begin
      for (int k = 0; k < 8; k++) counts[k] = req_tdata[CORE_W + CNT_W*k +: CNT_W];
      prev[CAT_IDLE]  = rd_row_ff   ? rd_idle_ff : '0;
      prev[CAT_USER]  = rd_row_ff   ? rd_user_ff : '0;
      prev[CAT_SYS]   = rd_row_ff   ? rd_sys_ff  : '0;
      prev[CAT_IOW]   = rd_iow_v_ff ? rd_iow_ff  : '0;
      prev[CAT_TOTAL] = rd_row_ff   ? rd_tot_ff  : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (accept) state_in = req_in_range ? ST_READ : ST_WRITE;
         ST_READ:      state_in = ST_LOAD;
         ST_LOAD:      state_in = ST_SERIAL;
         ST_SERIAL:    if (cnt_ff == 7'(SERIAL_LEN - 1)) state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (div_done) state_in = (cat_ff == 2'(CAT_IOW)) ? ST_WRITE : ST_DIV_START;
         ST_WRITE:     if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_tready = 1'b0;
      load_prev  = 1'b0;
      step       = 1'b0;
      div_start  = 1'b0;
      mem_we     = 1'b0;
      case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_LOAD:      load_prev  = 1'b1;
         ST_SERIAL:    step       = 1'b1;
         ST_DIV_START: div_start  = 1'b1;
         ST_WRITE:     mem_we     = out_free & in_range_ff;
         default:      req_tready = 1'b0;
      endcase
   end

   always_comb begin
      if (flags.num_zero[cat_ff]) share_sel = '0;
      else if (flags.den_zero || flags.cat_ge[cat_ff]) share_sel = SHARE_FULL;
      else share_sel = quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_EIGHT;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         iow_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) mode_ff <= csr_wdata;
         if (state_ff == ST_WRITE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (mem_we) begin
            row_valid_ff[addr] <= 1'b1;
            if (mode_ff != MODE_FOUR) iow_valid_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         core_ff     <= req_tdata[CORE_W-1:0];
         in_range_ff <= req_in_range;
      end
      if (state_ff == ST_LOAD) begin
         cnt_ff <= '0;
         cat_ff <= '0;
      end
      if (step) cnt_ff <= cnt_ff + 7'd1;
      if (state_ff == ST_DIV_WAIT && div_done) begin
         share_ff[cat_ff] <= share_sel;
         cat_ff           <= cat_ff + 2'd1;
      end
      if (state_ff == ST_WRITE && out_free) begin
         rsp_data_ff <= {5'b0,
                         (in_range_ff && mode_ff != MODE_FOUR) ? share_ff[CAT_IOW] : '0,
                         in_range_ff ? share_ff[CAT_SYS]  : '0,
                         in_range_ff ? share_ff[CAT_USER] : '0,
                         in_range_ff ? share_ff[CAT_IDLE] : '0,
                         core_ff};
      end
   end

   // per-core store
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_idle_ff  <= mem_idle[addr];
         rd_user_ff  <= mem_user[addr];
         rd_sys_ff   <= mem_sys[addr];
         rd_iow_ff   <= mem_iow[addr];
         rd_tot_ff   <= mem_tot[addr];
         rd_row_ff   <= row_valid_ff[addr];
         rd_iow_v_ff <= iow_valid_ff[addr];
      end
      if (mem_we) begin
         mem_idle[addr] <= cur_idle;
         mem_user[addr] <= cur_user;
         mem_sys[addr]  <= new_sys;
         mem_tot[addr]  <= new_total;
         if (mode_ff != MODE_FOUR) mem_iow[addr] <= cur_iow;
      end
   end

   tsm_front u_front (
      .clock     (clock),
      .mode      (mode_ff),
      .load_cnt  (accept),
      .counts    (counts),
      .load_prev (load_prev),
      .prev      (prev),
      .step      (step),
      .bit_idx   (cnt_ff),
      .prod      (prod),
      .den       (den),
      .flags     (flags),
      .new_total (new_total),
      .new_sys   (new_sys),
      .cur_idle  (cur_idle),
      .cur_user  (cur_user),
      .cur_iow   (cur_iow)
   );

   tsm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .prod  (prod[cat_ff]),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/tsm_front.sv @@
// bit-serial front end: counter sums, deltas, times-25 products and compares
// depends on tsm_pkg

module tsm_front (
   input  logic                  clock,
   input  logic [1:0]            mode,
   input  logic                  load_cnt,
   input  tsm_pkg::tsm_counts_type counts,
   input  logic                  load_prev,
   input  tsm_pkg::tsm_prev_type prev,
   input  logic                  step,
   input  logic [6:0]            bit_idx,
   output tsm_pkg::tsm_prod_type prod,
   output logic [63:0]           den,
   output tsm_pkg::tsm_flags_type flags,
   output logic [63:0]           new_total,
   output logic [63:0]           new_sys,
   output logic [63:0]           cur_idle,
   output logic [63:0]           cur_user,
   output logic [63:0]           cur_iow
);
   import tsm_pkg::*;

   tsm_counts_type cnt_ff, cnt_in;
   tsm_prev_type   prev_ff, prev_in;
   tsm_prod_type   m_ff, m_in;
   logic [CNT_W-1:0] den_ff, den_in, tot_ff, tot_in, sys_ff, sys_in;
   logic [4:0]     br_ff, br_in;
   logic [3:0][3:0] hist_ff, hist_in;
   logic [3:0][1:0] cm_ff, cm_in;
   logic [1:0]     csys_ff, csys_in;
   logic [2:0]     ctot_ff, ctot_in;
   tsm_flags_type  flags_ff, flags_in;

   logic           active, nf, eight, sys_bit, tot_bit;
   logic [7:0]     b;
   logic [4:0]     pb, a, d;
   logic [2:0]     sys_sum;
   logic [3:0]     tot_sum;
   logic [3:0][2:0] msum;

   always_comb begin
      active  = bit_idx < 7'(CNT_W);
      nf      = mode != MODE_FOUR;
      eight   = nf && (mode != MODE_SEVEN);
      for (int k = 0; k < 8; k++) b[k] = cnt_ff[k][0] & active;
      for (int k = 0; k < 5; k++) pb[k] = prev_ff[k][0] & active;
      sys_sum = 3'(b[IX_SYS]) + 3'(b[IX_IRQ] & nf) + 3'(b[IX_SIRQ] & nf) + 3'(csys_ff);
      tot_sum = 4'(b[IX_USER]) + 4'(b[IX_NICE]) + 4'(b[IX_SYS]) + 4'(b[IX_IDLE])
              + 4'(b[IX_IOW] & nf) + 4'(b[IX_IRQ] & nf) + 4'(b[IX_SIRQ] & nf)
              + 4'(b[IX_STEAL] & eight) + 4'(ctot_ff);
      sys_bit = sys_sum[0];
      tot_bit = tot_sum[0];
      a[CAT_IDLE]  = b[IX_IDLE];
      a[CAT_USER]  = b[IX_USER];
      a[CAT_SYS]   = sys_bit;
      a[CAT_IOW]   = b[IX_IOW];
      a[CAT_TOTAL] = tot_bit;
      for (int k = 0; k < 5; k++) begin
         d[k]     = (a[k] ^ pb[k] ^ br_ff[k]) & active;
         br_in[k] = (~a[k] & pb[k]) | (~(a[k] ^ pb[k]) & br_ff[k]);
      end
      for (int c = 0; c < 4; c++) begin
         msum[c] = 3'(d[c]) + 3'(hist_ff[c][2]) + 3'(hist_ff[c][3]) + 3'(cm_ff[c]);
      end

      cnt_in   = cnt_ff;
      prev_in  = prev_ff;
      m_in     = m_ff;
      den_in   = den_ff;
      tot_in   = tot_ff;
      sys_in   = sys_ff;
      hist_in  = hist_ff;
      cm_in    = cm_ff;
      csys_in  = csys_ff;
      ctot_in  = ctot_ff;
      flags_in = flags_ff;

      if (load_cnt) begin
         cnt_in = counts;
      end
      if (load_prev) begin
         prev_in  = prev;
         br_in    = '0;
         hist_in  = '0;
         cm_in    = '0;
         csys_in  = '0;
         ctot_in  = '0;
         flags_in = '{num_zero: 4'b1111, cat_ge: 4'b1111, den_zero: 1'b1};
      end else if (step) begin
         csys_in = sys_sum[2:1];
         ctot_in = tot_sum[3:1];
         for (int c = 0; c < 4; c++) begin
            cm_in[c]   = msum[c][2:1];
            hist_in[c] = {hist_ff[c][2:0], d[c]};
            m_in[c]    = {msum[c][0], m_ff[c][M_W-1:1]};
            if (d[c]) flags_in.num_zero[c] = 1'b0;
            if (d[c] != d[CAT_TOTAL]) flags_in.cat_ge[c] = d[c];
         end
         if (d[CAT_TOTAL]) flags_in.den_zero = 1'b0;
         if (active) begin
            for (int k = 0; k < 8; k++) cnt_in[k] = {cnt_ff[k][0], cnt_ff[k][CNT_W-1:1]};
            for (int k = 0; k < 5; k++) prev_in[k] = {1'b0, prev_ff[k][CNT_W-1:1]};
            den_in = {d[CAT_TOTAL], den_ff[CNT_W-1:1]};
            tot_in = {tot_bit, tot_ff[CNT_W-1:1]};
            sys_in = {sys_bit, sys_ff[CNT_W-1:1]};
         end
      end else begin
         br_in = br_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      prev_ff  <= prev_in;
      m_ff     <= m_in;
      den_ff   <= den_in;
      tot_ff   <= tot_in;
      sys_ff   <= sys_in;
      br_ff    <= br_in;
      hist_ff  <= hist_in;
      cm_ff    <= cm_in;
      csys_ff  <= csys_in;
      ctot_ff  <= ctot_in;
      flags_ff <= flags_in;
   end

   assign prod      = m_ff;
   assign den       = den_ff;
   assign flags     = flags_ff;
   assign new_total = tot_ff;
   assign new_sys   = sys_ff;
   assign cur_idle  = cnt_ff[IX_IDLE];
   assign cur_user  = cnt_ff[IX_USER];
   assign cur_iow   = cnt_ff[IX_IOW];

endmodule

@@ rtl/tsm_div.sv @@
// restoring divider, one quotient bit per cycle, fifteen bits per share
// depends on tsm_pkg

module tsm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tsm_pkg::M_W-1:0]   prod,
   input  logic [63:0]               den,
   output logic                      done,
   output logic [tsm_pkg::SHARE_W-1:0] quot
);
   import tsm_pkg::*;

   logic               busy_ff, busy_in, done_ff, done_in;
   logic [3:0]         step_ff, step_in;
   logic [CNT_W-1:0]   r_ff, r_in;
   logic [SHARE_W-1:0] sh_ff, sh_in, q_ff, q_in;
   logic [CNT_W:0]     r2, diff;
   logic               take;

   always_comb begin
      r2      = {r_ff, sh_ff[SHARE_W-1]};
      diff    = r2 - {1'b0, den};
      take    = r2 >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      r_in    = r_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         r_in    = prod[M_W-1:5];
         sh_in   = {prod[4:0], 10'b0};
      end else if (busy_ff) begin
         r_in    = take ? diff[CNT_W-1:0] : r2[CNT_W-1:0];
         q_in    = {q_ff[SHARE_W-2:0], take};
         sh_in   = {sh_ff[SHARE_W-2:0], 1'b0};
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      r_ff    <= r_in;
      sh_ff   <= sh_in;
      q_ff    <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
